// ----- sv/sws_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding-window sender package
// Shared types and codes for the sliding-window ARQ sender.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int SLOTS_DEF = 32;
  localparam int MAX_RES   = 32;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_NEW   = 2'd1;
  localparam logic [1:0] OP_ACK   = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic [2:0] KIND_SEND   = 3'd0;
  localparam logic [2:0] KIND_RETX   = 3'd1;
  localparam logic [2:0] KIND_REFUSE = 3'd2;
  localparam logic [2:0] KIND_STATUS = 3'd3;
  localparam logic [2:0] KIND_FAIL   = 3'd4;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_RETRIES = 2'd1;
  localparam logic [1:0] REG_WINDOW  = 2'd2;

  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [2:0]  RETRIES_RST = 3'd5;
  localparam logic [5:0]  WINDOW_RST  = 6'd20;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] ack_number;
    logic        ack_flag;
    logic        checksum_ok;
  } in_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] sequence_res;
    logic [2:0]  retry_count;
    logic [5:0]  outstanding;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] age;
    logic [2:0]  retries;
  } ent_t;

endpackage

// ----- sv/sliding_window_sender_top.sv -----
// ----------------------------------------------------------------------------
// Sliding-window sender
// Sender half of a sliding-window ARQ with cumulative acknowledgements.
//
//   Channel  Ports                            Transfer
//   input    start, busy, in_data             start high while busy is low
//   result   out_valid, out_data              out_valid high, one cycle
//   config   cfg_we, cfg_index, cfg_wdata     cfg_we high
//
// For start and new packet the result shows in the next cycle. An ack records
// its target, then frees the acknowledged slots one by one before its result.
// A tick walks the outstanding slots twice through the single read port of
// the slot memory; results of the second walk come at most one per cycle.
// Reset is synchronous and needs no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module sliding_window_sender_top #(
  parameter int SLOTS = sws_pkg::SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  sws_pkg::in_t  in_data,
  output logic         out_valid,
  output sws_pkg::out_t out_data,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);
  import sws_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WCAP   = (SLOTS < MAX_RES) ? SLOTS : MAX_RES;

  typedef enum logic [2:0] {S_IDLE, S_ACK, S_PASS1, S_PASS2} state_t;

  function automatic logic [SLOT_W-1:0] slot_adv(input logic [31:0] seq,
                                                 input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] r;
    if (seq == 32'hFFFF_FFFF) begin
      r = '0;
    end else if (slot == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = slot + 1'b1;
    end
    return r;
  endfunction

  state_t            state_r, state_nxt;
  logic [15:0]       tmo_r, tmo_nxt;
  logic [2:0]        maxr_r, maxr_nxt;
  logic [5:0]        win_r, win_nxt;
  logic [31:0]       base_r, base_nxt;
  logic [31:0]       next_r, next_nxt;
  logic [SLOT_W-1:0] bslot_r, bslot_nxt;
  logic [SLOT_W-1:0] nslot_r, nslot_nxt;
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic              failed_r, failed_nxt;
  logic [31:0]       ack_tgt_r, ack_tgt_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [5:0]        wend_r, wend_nxt;
  logic [5:0]        lastix_r, lastix_nxt;
  logic              fail_r, fail_nxt;
  logic [5:0]        rd_idx_r, rd_idx_nxt;
  logic [31:0]       rd_seq_r, rd_seq_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic              pv_r, pv_nxt;
  logic [5:0]        pi_r, pi_nxt;
  logic [31:0]       pseq_r, pseq_nxt;
  logic [SLOT_W-1:0] pslot_r, pslot_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  ent_t              mem [SLOTS];
  ent_t              mem_q;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  ent_t              mem_wdata;

  logic [31:0] cnt_full;
  logic [5:0]  eff_win;
  logic [31:0] ack_d;
  logic        ack_take;
  logic [5:0]  lim;
  logic        issue;
  logic [15:0] age1;
  logic        tmo_hit;
  logic        can_retry;
  logic        pvalid;
  logic        walk_done;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[rd_slot_r];
  end

  always_comb begin
    cnt_full = next_r - base_r;
    if (win_r == 6'd0) begin
      eff_win = 6'd1;
    end else if (win_r > 6'(WCAP)) begin
      eff_win = 6'(WCAP);
    end else begin
      eff_win = win_r;
    end
    ack_d    = in_data.ack_number - base_r;
    ack_take = in_data.checksum_ok && in_data.ack_flag && (ack_d != 32'd0) &&
               (ack_d <= cnt_full);
    lim       = (state_r == S_PASS1) ? cnt_r : wend_r;
    issue     = (rd_idx_r < lim);
    walk_done = !pv_r && !issue;
    age1      = (mem_q.age == 16'hFFFF) ? mem_q.age : mem_q.age + 16'd1;
    tmo_hit   = (age1 > tmo_r);
    can_retry = (mem_q.retries < maxr_r);
    pvalid    = pv_r && valid_r[pslot_r];
  end

  always_comb begin
    state_nxt     = state_r;
    tmo_nxt       = tmo_r;
    maxr_nxt      = maxr_r;
    win_nxt       = win_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    bslot_nxt     = bslot_r;
    nslot_nxt     = nslot_r;
    valid_nxt     = valid_r;
    failed_nxt    = failed_r;
    ack_tgt_nxt   = ack_tgt_r;
    cnt_nxt       = cnt_r;
    wend_nxt      = wend_r;
    lastix_nxt    = lastix_r;
    fail_nxt      = fail_r;
    rd_idx_nxt    = rd_idx_r;
    rd_seq_nxt    = rd_seq_r;
    rd_slot_nxt   = rd_slot_r;
    pv_nxt        = 1'b0;
    pi_nxt        = pi_r;
    pseq_nxt      = pseq_r;
    pslot_nxt     = pslot_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = pslot_r;
    mem_wdata     = '{age: age1, retries: mem_q.retries};

    if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT: tmo_nxt  = cfg_wdata;
        REG_RETRIES: maxr_nxt = cfg_wdata[2:0];
        REG_WINDOW:  win_nxt  = cfg_wdata[5:0];
        default: ;
      endcase
    end

    if ((state_r == S_PASS1 || state_r == S_PASS2) && issue) begin
      pv_nxt      = 1'b1;
      pi_nxt      = rd_idx_r;
      pseq_nxt    = rd_seq_r;
      pslot_nxt   = rd_slot_r;
      rd_idx_nxt  = rd_idx_r + 6'd1;
      rd_seq_nxt  = rd_seq_r + 32'd1;
      rd_slot_nxt = slot_adv(rd_seq_r, rd_slot_r);
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_data.opcode)
            OP_START: begin
              base_nxt     = '0;
              next_nxt     = '0;
              bslot_nxt    = '0;
              nslot_nxt    = '0;
              valid_nxt    = '0;
              failed_nxt   = 1'b0;
              out_valid_nxt = 1'b1;
              out_data_nxt = '{result_kind: KIND_STATUS, sequence_res: 32'd0,
                               retry_count: 3'd0, outstanding: 6'd0, last: 1'b1};
            end
            OP_NEW: begin
              out_valid_nxt = 1'b1;
              if (failed_r || (cnt_full >= 32'(eff_win))) begin
                out_data_nxt = '{result_kind: KIND_REFUSE, sequence_res: next_r,
                                 retry_count: 3'd0, outstanding: cnt_full[5:0],
                                 last: 1'b1};
              end else begin
                mem_we             = 1'b1;
                mem_waddr          = nslot_r;
                mem_wdata          = '{age: 16'd0, retries: 3'd0};
                valid_nxt[nslot_r] = 1'b1;
                next_nxt           = next_r + 32'd1;
                nslot_nxt          = slot_adv(next_r, nslot_r);
                out_data_nxt = '{result_kind: KIND_SEND, sequence_res: next_r,
                                 retry_count: 3'd0,
                                 outstanding: cnt_full[5:0] + 6'd1, last: 1'b1};
              end
            end
            OP_ACK: begin
              ack_tgt_nxt = ack_take ? in_data.ack_number : base_r;
              state_nxt   = S_ACK;
            end
            default: begin
              cnt_nxt     = cnt_full[5:0];
              fail_nxt    = 1'b0;
              lastix_nxt  = '0;
              rd_idx_nxt  = '0;
              rd_seq_nxt  = base_r;
              rd_slot_nxt = bslot_r;
              state_nxt   = S_PASS1;
            end
          endcase
        end
      end
      S_ACK: begin
        if (base_r == ack_tgt_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = '{result_kind: KIND_STATUS, sequence_res: base_r,
                           retry_count: 3'd0, outstanding: cnt_full[5:0],
                           last: 1'b1};
          state_nxt = S_IDLE;
        end else begin
          valid_nxt[bslot_r] = 1'b0;
          base_nxt           = base_r + 32'd1;
          bslot_nxt          = slot_adv(base_r, bslot_r);
        end
      end
      S_PASS1: begin
        if (pvalid && tmo_hit && !can_retry) begin
          fail_nxt    = 1'b1;
          lastix_nxt  = pi_r;
          wend_nxt    = pi_r + 6'd1;
          pv_nxt      = 1'b0;
          rd_idx_nxt  = '0;
          rd_seq_nxt  = base_r;
          rd_slot_nxt = bslot_r;
          state_nxt   = S_PASS2;
        end else begin
          if (pvalid && tmo_hit) begin
            lastix_nxt = pi_r;
          end
          if (walk_done) begin
            wend_nxt    = cnt_r;
            rd_idx_nxt  = '0;
            rd_seq_nxt  = base_r;
            rd_slot_nxt = bslot_r;
            state_nxt   = S_PASS2;
          end
        end
      end
      S_PASS2: begin
        if (pvalid) begin
          if (tmo_hit && can_retry) begin
            mem_we        = 1'b1;
            mem_wdata     = '{age: 16'd0, retries: mem_q.retries + 3'd1};
            out_valid_nxt = 1'b1;
            out_data_nxt = '{result_kind: KIND_RETX, sequence_res: pseq_r,
                             retry_count: mem_q.retries + 3'd1,
                             outstanding: fail_r ? 6'd0 : cnt_r,
                             last: (pi_r == lastix_r)};
          end else if (tmo_hit) begin
            out_valid_nxt = 1'b1;
            out_data_nxt = '{result_kind: KIND_FAIL, sequence_res: pseq_r,
                             retry_count: mem_q.retries, outstanding: 6'd0,
                             last: 1'b1};
            valid_nxt  = '0;
            base_nxt   = next_r;
            bslot_nxt  = nslot_r;
            failed_nxt = 1'b1;
            pv_nxt     = 1'b0;
            state_nxt  = S_IDLE;
          end else begin
            mem_we = 1'b1;
          end
        end
        if (walk_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tmo_r       <= TIMEOUT_RST;
      maxr_r      <= RETRIES_RST;
      win_r       <= WINDOW_RST;
      base_r      <= '0;
      next_r      <= '0;
      bslot_r     <= '0;
      nslot_r     <= '0;
      valid_r     <= '0;
      failed_r    <= 1'b0;
      fail_r      <= 1'b0;
      pv_r        <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tmo_r       <= tmo_nxt;
      maxr_r      <= maxr_nxt;
      win_r       <= win_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      bslot_r     <= bslot_nxt;
      nslot_r     <= nslot_nxt;
      valid_r     <= valid_nxt;
      failed_r    <= failed_nxt;
      fail_r      <= fail_nxt;
      pv_r        <= pv_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ack_tgt_r  <= ack_tgt_nxt;
    cnt_r      <= cnt_nxt;
    wend_r     <= wend_nxt;
    lastix_r   <= lastix_nxt;
    rd_seq_r   <= rd_seq_nxt;
    rd_slot_r  <= rd_slot_nxt;
    pi_r       <= pi_nxt;
    pseq_r     <= pseq_nxt;
    pslot_r    <= pslot_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
